// File: hw/rtl/mrm_pkg.sv
// Shared types and constants for the 4x4 row matrix multiplier.
// Used by every stage module and by the top level; depends on nothing.
package mrm_pkg;

    localparam int N_DIM  = 4;
    localparam int ELEM_W = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ROW_W  = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } t_op;

    typedef logic [N_DIM-1:0][ELEM_W-1:0] t_elems;

    // products indexed [k][col]
    typedef struct packed {
        logic [ROW_W-1:0]                        row;
        logic [N_DIM-1:0][N_DIM-1:0][PROD_W-1:0] prod;
    } t_prod_beat;

    typedef struct packed {
        logic [ROW_W-1:0]             row;
        logic [N_DIM-1:0][SUM_W-1:0]  sum;
    } t_sum_beat;

    typedef struct packed {
        logic [ROW_W-1:0]             row;
        logic [N_DIM-1:0][ELEM_W-1:0] prod;
        logic                         overflow;
    } t_out_beat;

endpackage

// File: hw/rtl/mrm_mul_stage.sv
// Stage 1: holds matrix B and forms the sixteen 64-bit products of a row.
// Depends on mrm_pkg.
module mrm_mul_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mrm_pkg::t_op       i_op,
    input  logic [1:0]         i_row,
    input  mrm_pkg::t_elems    i_elem,
    input  logic               i_next_en,
    output logic               o_valid,
    output mrm_pkg::t_prod_beat o_data
);
    import mrm_pkg::*;

    logic [N_DIM-1:0][N_DIM-1:0][ELEM_W-1:0] r_b;
    logic                                    r_valid;
    t_prod_beat                              r_data;
    t_prod_beat                              n_data;
    logic                                    w_en;
    logic                                    w_accept;

    assign w_en     = !r_valid || i_next_en;
    assign w_accept = i_valid && w_en;
    assign o_ready  = w_en;

    // B as it stands before this beat's edge is what a multiply sees
    always_comb begin
        n_data.row = i_row;
        for (int k = 0; k < N_DIM; k++) begin
            for (int c = 0; c < N_DIM; c++) begin
                n_data.prod[k][c] =
                    $signed({{ELEM_W{i_elem[k][ELEM_W-1]}}, i_elem[k]}) *
                    $signed({{ELEM_W{r_b[k][c][ELEM_W-1]}}, r_b[k][c]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_op == OP_LOAD) begin
            r_b[i_row] <= i_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_accept && (i_op == OP_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_op == OP_MUL) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_load_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_LOAD) |=> !r_valid)
        else $error("load beat entered the product stage");

endmodule

// File: hw/rtl/mrm_acc_stage.sv
// Stage 2: shifts each product right by the fraction width and sums per column.
// Depends on mrm_pkg.
module mrm_acc_stage #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_en,
    input  mrm_pkg::t_prod_beat i_data,
    input  logic                i_next_en,
    output logic                o_valid,
    output mrm_pkg::t_sum_beat  o_data
);
    import mrm_pkg::*;

    logic      r_valid;
    t_sum_beat r_data;
    t_sum_beat n_data;
    logic      w_en;

    assign w_en = !r_valid || i_next_en;
    assign o_en = w_en;

    always_comb begin
        n_data.row = i_data.row;
        for (int c = 0; c < N_DIM; c++) begin
            n_data.sum[c] = '0;
            for (int k = 0; k < N_DIM; k++) begin
                n_data.sum[c] = n_data.sum[c] +
                    SUM_W'($signed(i_data.prod[k][c]) >>> FRAC_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hw/rtl/mrm_sat_stage.sv
// Stage 3: saturates each column sum to 32 bits and holds the output beat.
// Depends on mrm_pkg.
module mrm_sat_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_en,
    input  mrm_pkg::t_sum_beat i_data,
    input  logic               i_out_ready,
    output logic               o_valid,
    output mrm_pkg::t_out_beat o_data
);
    import mrm_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (ELEM_W-1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic      r_valid;
    t_out_beat r_data;
    t_out_beat n_data;
    logic      w_en;

    assign w_en = !r_valid || i_out_ready;
    assign o_en = w_en;

    always_comb begin
        n_data.row      = i_data.row;
        n_data.overflow = 1'b0;
        for (int c = 0; c < N_DIM; c++) begin
            if ($signed(i_data.sum[c]) > SAT_MAX) begin
                n_data.prod[c]  = SAT_MAX[ELEM_W-1:0];
                n_data.overflow = 1'b1;
            end else if ($signed(i_data.sum[c]) < SAT_MIN) begin
                n_data.prod[c]  = SAT_MIN[ELEM_W-1:0];
                n_data.overflow = 1'b1;
            end else begin
                n_data.prod[c]  = i_data.sum[c][ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.overflow) |->
        (r_data.prod[0] == SAT_MAX[ELEM_W-1:0] || r_data.prod[0] == SAT_MIN[ELEM_W-1:0] ||
         r_data.prod[1] == SAT_MAX[ELEM_W-1:0] || r_data.prod[1] == SAT_MIN[ELEM_W-1:0] ||
         r_data.prod[2] == SAT_MAX[ELEM_W-1:0] || r_data.prod[2] == SAT_MIN[ELEM_W-1:0] ||
         r_data.prod[3] == SAT_MAX[ELEM_W-1:0] || r_data.prod[3] == SAT_MIN[ELEM_W-1:0]))
        else $error("overflow flagged without a saturated entry");

endmodule

// File: hw/rtl/matrix_row_multiply_4x4_core.sv
// Multiply beats pass the product, sum and saturation registers to m_tvalid; loads give no beat.
// Throughput: one beat per cycle while m_tready is high; the 32x32 multipliers, the four-term
// column add and the saturation each own one register stage; a stall holds each full stage.
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits only; matrix B
// holds no defined value until each row has been loaded.
module matrix_row_multiply_4x4_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // row_index, elem_0, elem_1, elem_2, elem_3, zero pad
    input  logic [0:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // out_row, prod_0, prod_1, prod_2, prod_3, zero pad
    output logic [0:0]   m_tuser   // overflow
);
    import mrm_pkg::*;

    localparam int PAD_W = 136 - ROW_W - N_DIM * ELEM_W;

    t_elems     w_elem;
    t_op        w_op;
    t_prod_beat w_prod;
    t_sum_beat  w_sum;
    t_out_beat  w_out;
    logic       w_prod_valid;
    logic       w_sum_valid;
    logic       w_acc_en;
    logic       w_sat_en;

    always_comb begin
        for (int k = 0; k < N_DIM; k++) begin
            w_elem[k] = s_tdata[ROW_W + k*ELEM_W +: ELEM_W];
        end
    end
    assign w_op = t_op'(s_tuser[0]);

    mrm_mul_stage u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_op      (w_op),
        .i_row     (s_tdata[ROW_W-1:0]),
        .i_elem    (w_elem),
        .i_next_en (w_acc_en),
        .o_valid   (w_prod_valid),
        .o_data    (w_prod)
    );

    mrm_acc_stage #(.FRAC_BITS(FRAC_BITS)) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_prod_valid),
        .o_en      (w_acc_en),
        .i_data    (w_prod),
        .i_next_en (w_sat_en),
        .o_valid   (w_sum_valid),
        .o_data    (w_sum)
    );

    mrm_sat_stage u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_sum_valid),
        .o_en        (w_sat_en),
        .i_data      (w_sum),
        .i_out_ready (m_tready),
        .o_valid     (m_tvalid),
        .o_data      (w_out)
    );

    assign m_tdata = {{PAD_W{1'b0}}, w_out.prod[3], w_out.prod[2], w_out.prod[1],
                      w_out.prod[0], w_out.row};
    assign m_tuser = w_out.overflow;

    // an empty output register must never block the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with the output register empty");

endmodule

// File: bench/matrix_row_multiply_4x4_core_checker.sv
// Row multiply checker: watches both stream channels of the 4x4 row multiplier.
// Keeps its own copy of matrix B and predicts each product row. Depends on mrm_pkg.
module matrix_row_multiply_4x4_core_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,  // row_index, elem_0, elem_1, elem_2, elem_3, zero pad
    input  logic [0:0]   i_s_tuser,  // operation
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,  // out_row, prod_0, prod_1, prod_2, prod_3, zero pad
    input  logic [0:0]   i_m_tuser,  // overflow
    output int           o_mismatch_count,
    output int           o_rows_pending,
    output int           o_rows_checked,
    output int           o_saturated_rows
);
    import mrm_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic [ELEM_W-1:0] b_store [N_DIM][N_DIM];  // [row][col]
    t_out_beat         product_rows [$];

    function automatic t_out_beat product_row(logic [ROW_W-1:0] row, t_elems a);
        t_out_beat r;
        longint    acc;
        longint    term;
        r.row      = row;
        r.overflow = 1'b0;
        for (int col = 0; col < N_DIM; col++) begin
            acc = 0;
            for (int k = 0; k < N_DIM; k++) begin
                term = longint'(signed'(a[k])) * longint'(signed'(b_store[k][col]));
                acc += term >>> FRAC_BITS;
            end
            if (acc > SAT_HI) begin
                acc        = SAT_HI;
                r.overflow = 1'b1;
            end else if (acc < SAT_LO) begin
                acc        = SAT_LO;
                r.overflow = 1'b1;
            end
            r.prod[col] = acc[ELEM_W-1:0];
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [ELEM_W-1:0] exp_v, logic [ELEM_W-1:0] act_v);
        o_mismatch_count++;
        if (o_mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_elems            a;
        t_out_beat         exp_beat;
        logic [ELEM_W-1:0] act_v;
        if (!i_rst_n) begin
            product_rows.delete();
            o_mismatch_count = 0;
            o_rows_pending   = 0;
            o_rows_checked   = 0;
            o_saturated_rows = 0;
        end else begin
            // drain first so a same-edge push never pairs with this beat
            if (i_m_tvalid && i_m_tready) begin
                if (product_rows.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= 10)
                        $display("[%0t] product row with nothing expected: tdata %h",
                                 $realtime, i_m_tdata);
                end else begin
                    exp_beat = product_rows.pop_front();
                    o_rows_checked++;
                    if (exp_beat.overflow)
                        o_saturated_rows++;
                    if (i_m_tdata[ROW_W-1:0] != exp_beat.row)
                        note_mismatch("out_row", ELEM_W'(exp_beat.row),
                                      ELEM_W'(i_m_tdata[ROW_W-1:0]));
                    for (int col = 0; col < N_DIM; col++) begin
                        act_v = i_m_tdata[ROW_W + ELEM_W*col +: ELEM_W];
                        if (act_v != exp_beat.prod[col])
                            note_mismatch($sformatf("prod_%0d", col), exp_beat.prod[col], act_v);
                    end
                    if (i_m_tuser[0] != exp_beat.overflow)
                        note_mismatch("overflow", ELEM_W'(exp_beat.overflow),
                                      ELEM_W'(i_m_tuser[0]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                for (int k = 0; k < N_DIM; k++)
                    a[k] = i_s_tdata[ROW_W + ELEM_W*k +: ELEM_W];
                if (t_op'(i_s_tuser[0]) == OP_LOAD) begin
                    for (int col = 0; col < N_DIM; col++)
                        b_store[i_s_tdata[ROW_W-1:0]][col] = a[col];
                end else begin
                    product_rows.push_back(product_row(i_s_tdata[ROW_W-1:0], a));
                end
            end
            o_rows_pending = product_rows.size();
        end
    end

endmodule

// File: bench/matrix_row_multiply_4x4_core_test.sv
// Stimulus and verdict for the 4x4 row multiplier: loads B, streams rows of A.
// Depends on mrm_pkg, matrix_row_multiply_4x4_core and the row multiply checker.
module matrix_row_multiply_4x4_core_test;
    import mrm_pkg::*;

    localparam int              RANDOM_ROWS = 1750;
    localparam int              CYCLE_LIMIT = 400000;
    localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [ELEM_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [ELEM_W-1:0] Q_NEG = 32'hFFFF_FFFF;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // row_index, elem_0, elem_1, elem_2, elem_3, zero pad
    logic [0:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // out_row, prod_0, prod_1, prod_2, prod_3, zero pad
    logic [0:0]   m_tuser;   // overflow

    int mismatch_count;
    int rows_pending;
    int rows_checked;
    int saturated_rows;
    int cycle_count = 0;
    int burst_left;
    int loads_sent;
    int muls_sent;

    matrix_row_multiply_4x4_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    matrix_row_multiply_4x4_core_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .o_mismatch_count (mismatch_count),
        .o_rows_pending   (rows_pending),
        .o_rows_checked   (rows_checked),
        .o_saturated_rows (saturated_rows)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still expected", cycle_count, rows_pending);
            $display("matrix_row_multiply_4x4_core_test: done, errors");
            $finish;
        end
    end

    // receiver: switch at random between stall modes
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((phase % 7) < 3);
            endcase
        end
    end

    function automatic logic [ELEM_W-1:0] pick_elem();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;  // within +-8.0
            4, 5, 6:    v = $urandom;
            7:          v = Q_MAX;
            8:          v = Q_MIN;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = Q_NEG;
                    2:       v = 32'h1;
                    default: v = Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    // present one beat, hold until accepted, then maybe open a gap
    task automatic send_row(t_op op, logic [ROW_W-1:0] row, t_elems e);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, e, row};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        if (op == OP_LOAD)
            loads_sent++;
        else
            muls_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic load_all_rows(logic [ELEM_W-1:0] v);
        for (int r = 0; r < N_DIM; r++)
            send_row(OP_LOAD, r[ROW_W-1:0], {v, v, v, v});
    endtask

    initial begin
        t_elems e;
        burst_left  = 0;
        loads_sent  = 0;
        muls_sent   = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOAD;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity B: product rows equal the rows of A
        for (int r = 0; r < N_DIM; r++) begin
            e    = '0;
            e[r] = Q_ONE;
            send_row(OP_LOAD, r[ROW_W-1:0], e);
        end
        send_row(OP_MUL, 2'd0, {Q_NEG, 32'h0, Q_MIN, Q_MAX});
        send_row(OP_MUL, 2'd1, {32'hFFFF_8000, 32'h0000_8000, Q_NEG, 32'h1});
        send_row(OP_MUL, 2'd2, {$urandom, $urandom, $urandom, $urandom});
        send_row(OP_MUL, 2'd3, '0);

        // reload row 0 with the smallest step: negative products round down
        send_row(OP_LOAD, 2'd0, {32'h1, 32'h1, 32'h1, 32'h1});
        send_row(OP_MUL, 2'd2, {32'h0, 32'h0, 32'h0, Q_NEG});

        // saturation both ways and a cancellation without saturation
        load_all_rows(Q_MAX);
        send_row(OP_MUL, 2'd1, {Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        send_row(OP_MUL, 2'd3, {Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        load_all_rows(Q_MIN);
        send_row(OP_MUL, 2'd0, {Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        send_row(OP_MUL, 2'd2, {Q_MIN, Q_MAX, Q_MIN, Q_MAX});
        send_row(OP_MUL, 2'd3, {Q_MAX, Q_MAX, Q_MAX, Q_MAX});

        // random rows; all of B is loaded by now so any row may be read
        repeat (RANDOM_ROWS) begin
            for (int k = 0; k < N_DIM; k++)
                e[k] = pick_elem();
            send_row(($urandom_range(0, 9) < 3) ? OP_LOAD : OP_MUL,
                     ROW_W'($urandom_range(0, 3)), e);
        end
        s_tvalid <= 1'b0;

        @(negedge i_clk);
        while (rows_pending != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d loads of B and %0d multiplies in %0d cycles", loads_sent, muls_sent,
                 cycle_count);
        $display("checked %0d product rows, %0d of them saturated", rows_checked, saturated_rows);
        if (mismatch_count == 0)
            $display("matrix_row_multiply_4x4_core_test: done, clean");
        else
            $display("matrix_row_multiply_4x4_core_test: done, errors");
        $finish;
    end

endmodule
